/* rtl/icg_pkg.sv */
// ----------------------------------------------------------------------------
// icg_pkg: shared types and constants of the im2col column generator
// Register indexes, item kinds and the clamped configuration bundle.
// ----------------------------------------------------------------------------
package icg_pkg;

	// Fixed field widths, sized for the largest supported dimension limits
	localparam int DIM_FW     = 13;   // holds 1..4096
	localparam int KER_FW     = 7;    // holds 1..64
	localparam int PAD_FW     = 16;
	localparam int PLN_FW     = 25;   // holds up to 4096*4096
	localparam int CFG_W      = 32;
	localparam int CH_REG_W   = 11;
	localparam int COL_W      = 40;
	localparam int PIX_W      = 32;
	localparam int LOAD_IDX_W = 14;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CHANNEL_COUNT = 3'd0,
		REG_SOURCE_SIZE   = 3'd1,
		REG_RESULT_SIZE   = 3'd2,
		REG_WINDOW_SIZE   = 3'd3,
		REG_PADDING_SIZE  = 3'd4,
		REG_STEP_SIZE     = 3'd5,
		REG_DILATION_SIZE = 3'd6
	} reg_idx_t;

	// Item kinds on the input stream
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	// Clamped configuration as seen by the walk and the address stages
	typedef struct packed {
		logic [DIM_FW-1:0] channels;
		logic [DIM_FW-1:0] src_h;
		logic [DIM_FW-1:0] src_w;
		logic [DIM_FW-1:0] res_h;
		logic [DIM_FW-1:0] res_w;
		logic [KER_FW-1:0] ker_h;
		logic [KER_FW-1:0] ker_w;
		logic [PAD_FW-1:0] pad_top;
		logic [PAD_FW-1:0] pad_left;
		logic [KER_FW-1:0] stride_v;
		logic [KER_FW-1:0] stride_w;
		logic [KER_FW-1:0] dil_v;
		logic [KER_FW-1:0] dil_h;
		logic [PLN_FW-1:0] plane_size;
	} cfg_t;

endpackage

/* rtl/icg_ram.sv */
// ----------------------------------------------------------------------------
// icg_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module icg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read into a registered output; hold read data when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/icg_cfg.sv */
// ----------------------------------------------------------------------------
// icg_cfg: configuration registers
// Clamps each dimension on write and keeps the plane size precomputed.
// ----------------------------------------------------------------------------
module icg_cfg #(
	parameter int DIM_MAX    = 1024,
	parameter int KERNEL_MAX = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  logic [2:0]     index,
	input  logic [31:0]    data,
	output icg_pkg::cfg_t  cfg,
	output logic           wr
);

	import icg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     idx_ok;

	function automatic logic [DIM_FW-1:0] clamp_dim(input logic [15:0] v);
		logic [DIM_FW-1:0] res;
		if (v == 16'd0) begin
			res = DIM_FW'(1);
		end else if (v > 16'(DIM_MAX)) begin
			res = DIM_FW'(DIM_MAX);
		end else begin
			res = v[DIM_FW-1:0];
		end
		return res;
	endfunction

	function automatic logic [KER_FW-1:0] clamp_ker(input logic [15:0] v);
		logic [KER_FW-1:0] res;
		if (v == 16'd0) begin
			res = KER_FW'(1);
		end else if (v > 16'(KERNEL_MAX)) begin
			res = KER_FW'(KERNEL_MAX);
		end else begin
			res = v[KER_FW-1:0];
		end
		return res;
	endfunction

	assign idx = reg_idx_t'(index);

	// Flag writes that land on a real register
	always_comb begin
		unique case (idx)
			REG_CHANNEL_COUNT, REG_SOURCE_SIZE, REG_RESULT_SIZE, REG_WINDOW_SIZE,
			REG_PADDING_SIZE, REG_STEP_SIZE, REG_DILATION_SIZE: idx_ok = 1'b1;
			default:                                            idx_ok = 1'b0;
		endcase
	end

	assign wr  = we & idx_ok;
	assign cfg = cfg_q;

	// Store clamped values (padding as written); the plane size follows each source size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels   <= DIM_FW'(1);
			cfg_q.src_h      <= DIM_FW'(1);
			cfg_q.src_w      <= DIM_FW'(1);
			cfg_q.res_h      <= DIM_FW'(1);
			cfg_q.res_w      <= DIM_FW'(1);
			cfg_q.ker_h      <= KER_FW'(1);
			cfg_q.ker_w      <= KER_FW'(1);
			cfg_q.pad_top    <= '0;
			cfg_q.pad_left   <= '0;
			cfg_q.stride_v   <= KER_FW'(1);
			cfg_q.stride_w   <= KER_FW'(1);
			cfg_q.dil_v      <= KER_FW'(1);
			cfg_q.dil_h      <= KER_FW'(1);
			cfg_q.plane_size <= PLN_FW'(1);
		end else if (we) begin
			unique case (idx)
				REG_CHANNEL_COUNT: begin
					cfg_q.channels <= clamp_dim(16'(data[CH_REG_W-1:0]));
				end
				REG_SOURCE_SIZE: begin
					cfg_q.src_h      <= clamp_dim(data[31:16]);
					cfg_q.src_w      <= clamp_dim(data[15:0]);
					cfg_q.plane_size <= PLN_FW'(clamp_dim(data[31:16]))
						* PLN_FW'(clamp_dim(data[15:0]));
				end
				REG_RESULT_SIZE: begin
					cfg_q.res_h <= clamp_dim(data[31:16]);
					cfg_q.res_w <= clamp_dim(data[15:0]);
				end
				REG_WINDOW_SIZE: begin
					cfg_q.ker_h <= clamp_ker(data[31:16]);
					cfg_q.ker_w <= clamp_ker(data[15:0]);
				end
				REG_PADDING_SIZE: begin
					cfg_q.pad_top  <= data[31:16];
					cfg_q.pad_left <= data[15:0];
				end
				REG_STEP_SIZE: begin
					cfg_q.stride_v <= clamp_ker(data[31:16]);
					cfg_q.stride_w <= clamp_ker(data[15:0]);
				end
				REG_DILATION_SIZE: begin
					cfg_q.dil_v <= clamp_ker(data[31:16]);
					cfg_q.dil_h <= clamp_ker(data[15:0]);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/icg_walk.sv */
// ----------------------------------------------------------------------------
// icg_walk: column matrix walker
// Nested counters with incrementally updated source coordinates and plane
// base; presents the current element and advances on each step transfer.
// ----------------------------------------------------------------------------
module icg_walk #(
	parameter int DIM_MAX    = 1024,
	parameter int KERNEL_MAX = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  icg_pkg::cfg_t                  cfg,
	input  logic                           cfg_wr,
	input  logic                           step,
	input  logic                           restart,
	output logic [$clog2(DIM_MAX)-1:0]     elem_row,
	output logic [$clog2(DIM_MAX)-1:0]     elem_col,
	output logic [3*$clog2(DIM_MAX)-1:0]   elem_base,
	output logic [icg_pkg::COL_W-1:0]      elem_index,
	output logic                           elem_pad,
	output logic                           elem_last
);

	import icg_pkg::*;

	localparam int CNT_W  = $clog2(DIM_MAX);
	localparam int KCNT_W = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
	localparam int POS_W  = $clog2(DIM_MAX * KERNEL_MAX + KERNEL_MAX * KERNEL_MAX + 1);
	localparam int CRD_W  = (POS_W + 1 > 18) ? POS_W + 1 : 18;
	localparam int BASE_W = 3 * $clog2(DIM_MAX);

	// Walk state
	logic              fresh_q;
	logic [CNT_W-1:0]  ch_q, or_q, oc_q;
	logic [KCNT_W-1:0] kr_q, kc_q;
	logic [CRD_W-1:0]  rbase_q, cbase_q, r_q, c_q;
	logic [BASE_W-1:0] base_q;
	logic [COL_W-1:0]  idx_q;

	// Current element, either from the state or from the first element
	logic              start;
	logic [CNT_W-1:0]  cur_ch, cur_or, cur_oc;
	logic [KCNT_W-1:0] cur_kr, cur_kc;
	logic [CRD_W-1:0]  cur_rbase, cur_cbase, cur_r, cur_c;
	logic [BASE_W-1:0] cur_base;
	logic [COL_W-1:0]  cur_idx;
	logic [CRD_W-1:0]  init_r, init_c;
	logic              oc_end, or_end, kc_end, kr_end, ch_end;
	logic              r_out, c_out;

	// Position after the current element
	logic              fresh_d;
	logic [CNT_W-1:0]  ch_d, or_d, oc_d;
	logic [KCNT_W-1:0] kr_d, kc_d;
	logic [CRD_W-1:0]  rbase_d, cbase_d, r_d, c_d;
	logic [BASE_W-1:0] base_d;

	assign start  = fresh_q | restart;
	assign init_r = CRD_W'(0) - CRD_W'(cfg.pad_top);
	assign init_c = CRD_W'(0) - CRD_W'(cfg.pad_left);

	assign cur_ch    = start ? '0 : ch_q;
	assign cur_kr    = start ? '0 : kr_q;
	assign cur_kc    = start ? '0 : kc_q;
	assign cur_or    = start ? '0 : or_q;
	assign cur_oc    = start ? '0 : oc_q;
	assign cur_rbase = start ? init_r : rbase_q;
	assign cur_cbase = start ? init_c : cbase_q;
	assign cur_r     = start ? init_r : r_q;
	assign cur_c     = start ? init_c : c_q;
	assign cur_base  = start ? '0 : base_q;
	assign cur_idx   = start ? '0 : idx_q;

	// Detect the end of each loop level
	assign oc_end = DIM_FW'(cur_oc) == cfg.res_w - DIM_FW'(1);
	assign or_end = DIM_FW'(cur_or) == cfg.res_h - DIM_FW'(1);
	assign kc_end = KER_FW'(cur_kc) == cfg.ker_w - KER_FW'(1);
	assign kr_end = KER_FW'(cur_kr) == cfg.ker_h - KER_FW'(1);
	assign ch_end = DIM_FW'(cur_ch) == cfg.channels - DIM_FW'(1);

	// Padding test: negative or at or past the source edge
	assign r_out = cur_r[CRD_W-1] || (cur_r >= CRD_W'(cfg.src_h));
	assign c_out = cur_c[CRD_W-1] || (cur_c >= CRD_W'(cfg.src_w));

	assign elem_row   = cur_r[CNT_W-1:0];
	assign elem_col   = cur_c[CNT_W-1:0];
	assign elem_base  = cur_base;
	assign elem_index = cur_idx;
	assign elem_pad   = r_out | c_out;
	assign elem_last  = oc_end & or_end & kc_end & kr_end & ch_end;

	// Step the innermost loop that has not reached its end
	always_comb begin
		fresh_d = 1'b0;
		ch_d    = cur_ch;
		kr_d    = cur_kr;
		kc_d    = cur_kc;
		or_d    = cur_or;
		oc_d    = cur_oc;
		rbase_d = cur_rbase;
		cbase_d = cur_cbase;
		r_d     = cur_r;
		c_d     = cur_c;
		base_d  = cur_base;
		priority if (elem_last) begin
			fresh_d = 1'b1;
		end else if (!oc_end) begin
			oc_d = cur_oc + CNT_W'(1);
			c_d  = cur_c + CRD_W'(cfg.stride_w);
		end else if (!or_end) begin
			oc_d = '0;
			or_d = cur_or + CNT_W'(1);
			c_d  = cur_cbase;
			r_d  = cur_r + CRD_W'(cfg.stride_v);
		end else if (!kc_end) begin
			oc_d    = '0;
			or_d    = '0;
			kc_d    = cur_kc + KCNT_W'(1);
			cbase_d = cur_cbase + CRD_W'(cfg.dil_h);
			c_d     = cur_cbase + CRD_W'(cfg.dil_h);
			r_d     = cur_rbase;
		end else if (!kr_end) begin
			oc_d    = '0;
			or_d    = '0;
			kc_d    = '0;
			kr_d    = cur_kr + KCNT_W'(1);
			rbase_d = cur_rbase + CRD_W'(cfg.dil_v);
			r_d     = cur_rbase + CRD_W'(cfg.dil_v);
			cbase_d = init_c;
			c_d     = init_c;
		end else begin
			oc_d    = '0;
			or_d    = '0;
			kc_d    = '0;
			kr_d    = '0;
			ch_d    = cur_ch + CNT_W'(1);
			rbase_d = init_r;
			r_d     = init_r;
			cbase_d = init_c;
			c_d     = init_c;
			base_d  = cur_base + BASE_W'(cfg.plane_size);
		end
	end

	// Advance the walk by one element on a step; a register write rewinds it instead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			ch_q    <= '0;
			kr_q    <= '0;
			kc_q    <= '0;
			or_q    <= '0;
			oc_q    <= '0;
			rbase_q <= '0;
			cbase_q <= '0;
			r_q     <= '0;
			c_q     <= '0;
			base_q  <= '0;
			idx_q   <= '0;
		end else if (cfg_wr) begin
			fresh_q <= 1'b1;
		end else if (step) begin
			fresh_q <= fresh_d;
			ch_q    <= ch_d;
			kr_q    <= kr_d;
			kc_q    <= kc_d;
			or_q    <= or_d;
			oc_q    <= oc_d;
			rbase_q <= rbase_d;
			cbase_q <= cbase_d;
			r_q     <= r_d;
			c_q     <= c_d;
			base_q  <= base_d;
			idx_q   <= cur_idx + COL_W'(1);
		end
	end

endmodule

/* rtl/im2col_column_generator_top.sv */
// Pipeline: walked element, row multiply, store read, output register; a load
// writes the store in the row offset stage. Throughput: one item per cycle
// unless the result side stalls, set by the single read and write port of
// the image store and the walk counters, which advance once per cycle.
// Reset: configuration returns to its defaults and the walk to the first
// element; image store contents are undefined until loaded.
// ----------------------------------------------------------------------------
// im2col_column_generator_top: im2col column generator
// Walks the column matrix, computes source addresses and reads pixel words
// from the image store, with loads and reads kept in stream order.
// ----------------------------------------------------------------------------
module im2col_column_generator_top #(
	parameter int IMAGE_WORDS = 16384,
	parameter int DIM_MAX     = 1024,
	parameter int KERNEL_MAX  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // load_index[13:0], load_value[45:14], restart[46]
	input  logic        s_axis_tuser,   // op[0]
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // value[31:0], column_index[71:32]
	output logic [1:0]  m_axis_tuser,   // is_padding[0], beyond_store[1]
	output logic        m_axis_tlast    // last
);

	import icg_pkg::*;

	localparam int CNT_W  = $clog2(DIM_MAX);
	localparam int BASE_W = 3 * $clog2(DIM_MAX);
	localparam int ADDR_W = $clog2(IMAGE_WORDS);
	localparam int SUM_W  = (BASE_W > ADDR_W) ? BASE_W : ADDR_W;

	cfg_t              cfg;
	logic              cfg_wr;
	logic              adv, accept;
	op_t               in_op;
	logic [CNT_W-1:0]  w_row, w_col;
	logic [BASE_W-1:0] w_base;
	logic [COL_W-1:0]  w_index;
	logic              w_pad, w_last;

	// Stage 1: walked element
	logic                  vld_s1, pad_s1, last_s1;
	op_t                   op_s1;
	logic [LOAD_IDX_W-1:0] ld_idx_s1;
	logic [PIX_W-1:0]      ld_val_s1;
	logic [CNT_W-1:0]      row_s1, col_s1;
	logic [BASE_W-1:0]     base_s1;
	logic [COL_W-1:0]      index_s1;

	// Stage 2: row offset and partial address
	logic                  vld_s2, pad_s2, last_s2;
	op_t                   op_s2;
	logic [LOAD_IDX_W-1:0] ld_idx_s2;
	logic [PIX_W-1:0]      ld_val_s2;
	logic [SUM_W-1:0]      prod_s2, part_s2;
	logic [COL_W-1:0]      index_s2;

	// Stage 3: store read returns
	logic                  vld_s3, pad_s3, beyond_s3, last_s3;
	op_t                   op_s3;
	logic [COL_W-1:0]      index_s3;

	// Output register
	logic                  out_valid_q, pad_q, beyond_q, last_q;
	logic [PIX_W-1:0]      value_q;
	logic [COL_W-1:0]      index_q;

	logic [SUM_W-1:0]      addr_s2;
	logic                  beyond_s2, ld_ok_s2, ram_we;
	logic [PIX_W-1:0]      ram_rdata;

	// Whole pipeline moves when the output register is free or being taken
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid & adv;
	assign in_op         = op_t'(s_axis_tuser);

	icg_cfg #(
		.DIM_MAX    (DIM_MAX),
		.KERNEL_MAX (KERNEL_MAX)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg),
		.wr     (cfg_wr)
	);

	icg_walk #(
		.DIM_MAX    (DIM_MAX),
		.KERNEL_MAX (KERNEL_MAX)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cfg_wr     (cfg_wr),
		.step       (accept && in_op == OP_STEP),
		.restart    (s_axis_tdata[46]),
		.elem_row   (w_row),
		.elem_col   (w_col),
		.elem_base  (w_base),
		.elem_index (w_index),
		.elem_pad   (w_pad),
		.elem_last  (w_last)
	);

	// Final address, store range check and load write, all in stage 2
	assign addr_s2   = prod_s2 + part_s2;
	assign beyond_s2 = !pad_s2 && (64'(addr_s2) >= 64'(IMAGE_WORDS));
	assign ld_ok_s2  = 64'(ld_idx_s2) < 64'(IMAGE_WORDS);
	assign ram_we    = adv && vld_s2 && op_s2 == OP_LOAD && ld_ok_s2;

	icg_ram #(
		.WIDTH (PIX_W),
		.DEPTH (IMAGE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(ld_idx_s2)),
		.wdata (ld_val_s2),
		.re    (adv),
		.raddr (addr_s2[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Stage valids and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= accept;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			out_valid_q <= vld_s3 && op_s3 == OP_STEP;
		end
	end

	// Advance the payload of every stage together
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= in_op;
			ld_idx_s1 <= s_axis_tdata[13:0];
			ld_val_s1 <= s_axis_tdata[45:14];
			row_s1    <= w_row;
			col_s1    <= w_col;
			base_s1   <= w_base;
			index_s1  <= w_index;
			pad_s1    <= w_pad;
			last_s1   <= w_last;

			op_s2     <= op_s1;
			ld_idx_s2 <= ld_idx_s1;
			ld_val_s2 <= ld_val_s1;
			prod_s2   <= SUM_W'(row_s1) * SUM_W'(cfg.src_w);
			part_s2   <= SUM_W'(base_s1) + SUM_W'(col_s1);
			index_s2  <= index_s1;
			pad_s2    <= pad_s1;
			last_s2   <= last_s1;

			op_s3     <= op_s2;
			index_s3  <= index_s2;
			pad_s3    <= pad_s2;
			beyond_s3 <= beyond_s2;
			last_s3   <= last_s2;

			value_q   <= (pad_s3 || beyond_s3) ? '0 : ram_rdata;
			index_q   <= index_s3;
			pad_q     <= pad_s3;
			beyond_q  <= beyond_s3;
			last_q    <= last_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {index_q, value_q};
	assign m_axis_tuser  = {beyond_q, pad_q};
	assign m_axis_tlast  = last_q;

endmodule

/* bench/icg_column_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icg_column_check: column element predictor and comparator
// Mirrors the configuration registers, the image store and the im2col walk,
// works out the column element that each step transfer must produce and
// compares every result transfer with the oldest element still due.
// ----------------------------------------------------------------------------
module icg_column_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // load_index[13:0], load_value[45:14], restart[46]
	input  logic        s_axis_tuser,   // op[0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,   // value[31:0], column_index[71:32]
	input  logic [1:0]  m_axis_tuser,   // is_padding[0], beyond_store[1]
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);

	import icg_pkg::*;

	localparam longint STORE_WORDS  = 16384;
	localparam longint DIM_LIMIT    = 1024;
	localparam longint KERNEL_LIMIT = 16;

	typedef struct packed {
		logic [31:0] value;
		logic [39:0] column;
		logic        padding;
		logic        beyond;
		logic        last;
	} element_t;

	// Mirrored registers
	logic [10:0] reg_channels;
	logic [31:0] reg_source, reg_result, reg_window, reg_padding, reg_step, reg_dilation;

	// Mirrored store and walk position
	logic [31:0] pixel_mem [0:16383];
	longint      walk_ch, walk_krow, walk_kcol, walk_orow, walk_ocol;
	logic [39:0] walk_column;

	element_t    elements_due [$];

	function automatic longint clamp_to(input longint v, input longint hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic rewind_walk();
		walk_ch     = 0;
		walk_krow   = 0;
		walk_kcol   = 0;
		walk_orow   = 0;
		walk_ocol   = 0;
		walk_column = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		element_t due_e;
		element_t got_e;
		element_t exp_e;
		longint   nc, sh, sw, dh, dw, kh, kw, ph, pw, th, tw, hh, hw;
		longint   row, col, addr;
		int       i;
		if (!arst_n) begin
			reg_channels = 11'd1;
			reg_source   = 32'h0001_0001;
			reg_result   = 32'h0001_0001;
			reg_window   = 32'h0001_0001;
			reg_padding  = 32'h0000_0000;
			reg_step     = 32'h0001_0001;
			reg_dilation = 32'h0001_0001;
			for (i = 0; i < STORE_WORDS; i++)
				pixel_mem[i] = '0;
			rewind_walk();
			elements_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// Register write: any known index rewinds the walk
			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNEL_COUNT: reg_channels = cfg_data[10:0];
					REG_SOURCE_SIZE:   reg_source   = cfg_data;
					REG_RESULT_SIZE:   reg_result   = cfg_data;
					REG_WINDOW_SIZE:   reg_window   = cfg_data;
					REG_PADDING_SIZE:  reg_padding  = cfg_data;
					REG_STEP_SIZE:     reg_step     = cfg_data;
					REG_DILATION_SIZE: reg_dilation = cfg_data;
					default: ;
				endcase
				if (cfg_index <= REG_DILATION_SIZE)
					rewind_walk();
			end

			// Compare a result transfer with the oldest element due
			if (m_axis_tvalid && m_axis_tready) begin
				got_e.value   = m_axis_tdata[31:0];
				got_e.column  = m_axis_tdata[71:32];
				got_e.padding = m_axis_tuser[0];
				got_e.beyond  = m_axis_tuser[1];
				got_e.last    = m_axis_tlast;
				if (elements_due.size() == 0) begin
					report_mismatch("result with nothing due", 64'(got_e.column), 64'(0));
				end else begin
					exp_e = elements_due.pop_front();
					if (got_e.value !== exp_e.value)
						report_mismatch("value", 64'(got_e.value), 64'(exp_e.value));
					if (got_e.column !== exp_e.column)
						report_mismatch("column_index", 64'(got_e.column),
							64'(exp_e.column));
					if (got_e.padding !== exp_e.padding)
						report_mismatch("is_padding", 64'(got_e.padding),
							64'(exp_e.padding));
					if (got_e.beyond !== exp_e.beyond)
						report_mismatch("beyond_store", 64'(got_e.beyond),
							64'(exp_e.beyond));
					if (got_e.last !== exp_e.last)
						report_mismatch("last", 64'(got_e.last), 64'(exp_e.last));
				end
			end

			// Input transfer: write the store or predict the next element
			if (s_axis_tvalid && s_axis_tready) begin
				if (op_t'(s_axis_tuser) == OP_LOAD) begin
					if (longint'(s_axis_tdata[13:0]) < STORE_WORDS)
						pixel_mem[s_axis_tdata[13:0]] = s_axis_tdata[45:14];
				end else begin
					if (s_axis_tdata[46])
						rewind_walk();
					nc = clamp_to(longint'(reg_channels), DIM_LIMIT);
					sh = clamp_to(longint'(reg_source[31:16]), DIM_LIMIT);
					sw = clamp_to(longint'(reg_source[15:0]), DIM_LIMIT);
					dh = clamp_to(longint'(reg_result[31:16]), DIM_LIMIT);
					dw = clamp_to(longint'(reg_result[15:0]), DIM_LIMIT);
					kh = clamp_to(longint'(reg_window[31:16]), KERNEL_LIMIT);
					kw = clamp_to(longint'(reg_window[15:0]), KERNEL_LIMIT);
					ph = longint'(reg_padding[31:16]);
					pw = longint'(reg_padding[15:0]);
					th = clamp_to(longint'(reg_step[31:16]), KERNEL_LIMIT);
					tw = clamp_to(longint'(reg_step[15:0]), KERNEL_LIMIT);
					hh = clamp_to(longint'(reg_dilation[31:16]), KERNEL_LIMIT);
					hw = clamp_to(longint'(reg_dilation[15:0]), KERNEL_LIMIT);

					row = walk_orow * th - ph + walk_krow * hh;
					col = walk_ocol * tw - pw + walk_kcol * hw;
					due_e.value   = '0;
					due_e.beyond  = 1'b0;
					due_e.column  = walk_column;
					due_e.padding = (row < 0 || row >= sh || col < 0 || col >= sw);
					if (!due_e.padding) begin
						addr = walk_ch * sh * sw + row * sw + col;
						if (addr < STORE_WORDS)
							due_e.value = pixel_mem[addr];
						else
							due_e.beyond = 1'b1;
					end
					due_e.last = (walk_ch == nc - 1 && walk_krow == kh - 1 &&
						walk_kcol == kw - 1 && walk_orow == dh - 1 && walk_ocol == dw - 1);
					elements_due.push_back(due_e);

					// Advance: output column fastest, channel slowest
					if (due_e.last) begin
						rewind_walk();
					end else begin
						walk_column = walk_column + 40'd1;
						walk_ocol++;
						if (walk_ocol >= dw) begin
							walk_ocol = 0;
							walk_orow++;
							if (walk_orow >= dh) begin
								walk_orow = 0;
								walk_kcol++;
								if (walk_kcol >= kw) begin
									walk_kcol = 0;
									walk_krow++;
									if (walk_krow >= kh) begin
										walk_krow = 0;
										walk_ch++;
										if (walk_ch >= nc)
											rewind_walk();
									end
								end
							end
						end
					end
				end
			end

			pending <= elements_due.size();
		end
	end

endmodule

/* bench/tb_im2col_column_generator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_im2col_column_generator_top: stimulus and verdict for the column generator
// Fills the image store, runs a directed walk through padding, store overrun,
// wrap and register cases, then random load and step traffic over several
// geometries with sender gaps and receiver stalls. The column check module
// predicts and compares; this module drives the ports and gives the verdict.
// ----------------------------------------------------------------------------
module tb_im2col_column_generator_top;
	import icg_pkg::*;

	localparam logic [2:0] UNUSED_REG_INDEX = 3'd7;
	localparam int         ITEMS_PER_PHASE  = 75;
	localparam int         PHASE_COUNT      = 8;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [2:0]  cfg_index     = '0;
	logic [31:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;   // load_index[13:0], load_value[45:14], restart[46]
	logic        s_axis_tuser  = 1'b0; // op[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;         // value[31:0], column_index[71:32]
	logic [1:0]  m_axis_tuser;         // is_padding[0], beyond_store[1]
	logic        m_axis_tlast;

	int fail_count;
	int pending;
	int gap_pct   = 0;
	int stall_pct = 0;

	always #2 clk = ~clk;

	im2col_column_generator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	icg_column_check u_column_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Stall the result side at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Present one item, with random gaps ahead of it, and hold until the transfer
	task automatic send_item(input op_t op, input logic [13:0] idx, input logic [31:0] word,
		input logic rst);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, rst, word, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Drop valid, wait until every element due has arrived, then let the pipe drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic program_geometry(input logic [31:0] channels, input logic [31:0] source,
		input logic [31:0] result, input logic [31:0] window, input logic [31:0] padding,
		input logic [31:0] step, input logic [31:0] dilation);
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, channels);
		write_reg(REG_SOURCE_SIZE, source);
		write_reg(REG_RESULT_SIZE, result);
		write_reg(REG_WINDOW_SIZE, window);
		write_reg(REG_PADDING_SIZE, padding);
		write_reg(REG_STEP_SIZE, step);
		write_reg(REG_DILATION_SIZE, dilation);
		cfg_we <= 1'b0;
	endtask

	// Stop a hung run
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] geo [7];
		int          i;
		int          p;
		int          n;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the low words and the few high words that the geometries below
		// read; every other source word is padding or lies past the store
		for (i = 0; i < 256; i++)
			send_item(OP_LOAD, 14'(i), $urandom, 1'(i));
		for (i = 5120; i < 5128; i++)
			send_item(OP_LOAD, 14'(i), $urandom, 1'(i));

		// Default geometry: every element is the last one
		send_item(OP_STEP, 14'($urandom), $urandom, 1'b0);
		send_item(OP_STEP, 14'($urandom), $urandom, 1'b1);
		send_item(OP_LOAD, 14'd0, 32'h0000_0000, 1'b1);
		send_item(OP_LOAD, 14'h3FFF, 32'hFFFF_FFFF, 1'b0);
		send_item(OP_STEP, 14'($urandom), $urandom, 1'b0);

		// Padded 3x3 window: border elements fall outside the source
		program_geometry(32'd2, 32'h0003_0003, 32'h0003_0003, 32'h0003_0003,
			32'h0001_0001, 32'h0001_0001, 32'h0001_0001);
		for (i = 0; i < 8; i++)
			send_item(OP_STEP, 14'($urandom), $urandom, i == 5);

		// Write past the register list: the walk goes on
		wait_idle();
		write_reg(UNUSED_REG_INDEX, $urandom);
		cfg_we <= 1'b0;
		for (i = 0; i < 3; i++)
			send_item(OP_STEP, 14'($urandom), $urandom, 1'b0);

		// Clamped 1024x1024 source with stride 16: reads run past the store
		program_geometry(32'd2, 32'hFFFF_FFFF, 32'h0002_0002, 32'h0001_0001,
			32'h0000_0000, 32'h0010_0010, 32'h0001_0001);
		for (i = 0; i < 8; i++)
			send_item(OP_STEP, 14'($urandom), $urandom, 1'b0);

		// Random traffic over several geometries and idle patterns
		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					geo = '{32'd2, 32'h0004_0004, 32'h0002_0003, 32'h0002_0002,
						32'h0001_0000, 32'h0002_0001, 32'h0001_0002};
				end
				1: begin
					geo = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
				end
				2: begin
					geo = '{32'h0000_07FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
						32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				end
				3: begin
					geo = '{32'd3, 32'h0400_0400, 32'h0002_0003, 32'h0002_0001,
						32'h0000_0000, 32'h0010_0003, 32'h0005_0001};
				end
				4: begin
					geo = '{32'd1, 32'h0007_0009, 32'h0003_0003, 32'h0003_0003,
						32'h0002_0002, 32'h0001_0001, 32'h0002_0001};
				end
				6: begin
					geo = '{32'd1024, 32'h8000_0001, 32'h0001_0001, 32'h0010_0010,
						32'h0000_0000, 32'h0001_0001, 32'h0010_0010};
				end
				default: begin
					geo[0] = $urandom_range(1, 4);
					geo[1] = {16'($urandom_range(1, 8)), 16'($urandom_range(1, 8))};
					geo[2] = {16'($urandom_range(1, 4)), 16'($urandom_range(1, 4))};
					geo[3] = {16'($urandom_range(1, 3)), 16'($urandom_range(1, 3))};
					geo[4] = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))};
					geo[5] = {16'($urandom_range(1, 3)), 16'($urandom_range(1, 3))};
					geo[6] = {16'($urandom_range(1, 3)), 16'($urandom_range(1, 3))};
				end
			endcase
			program_geometry(geo[0], geo[1], geo[2], geo[3], geo[4], geo[5], geo[6]);

			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 73; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 73; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// On odd phases, hold off halfway until the result side has caught up
				if (n == ITEMS_PER_PHASE / 2 && p[0])
					wait_idle();
				if ($urandom_range(99) < 25)
					send_item(OP_LOAD, 14'($urandom), $urandom, 1'($urandom_range(1)));
				else
					send_item(OP_STEP, 14'($urandom), $urandom, $urandom_range(99) < 3);
			end
		end

		// Drain and give the verdict
		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/icg_pkg.sv
rtl/icg_ram.sv
rtl/icg_cfg.sv
rtl/icg_walk.sv
rtl/im2col_column_generator_top.sv
bench/icg_column_check.sv
bench/tb_im2col_column_generator_top.sv
